// File: src/mcpe_pkg.sv
// Shared types, command codes and the CRC-7 step for the motor command packet encoder.
`default_nettype none

package mcpe_pkg;

    // Command kinds carried in the request
    localparam logic [3:0] FUNC_ALLSPEED = 4'd0;
    localparam logic [3:0] FUNC_SPEED    = 4'd1;
    localparam logic [3:0] FUNC_BRAKE    = 4'd2;
    localparam logic [3:0] FUNC_CRCON    = 4'd3;
    localparam logic [3:0] FUNC_CRCOFF   = 4'd4;
    localparam logic [3:0] FUNC_CLRFLAGS = 4'd5;
    localparam logic [3:0] FUNC_SETFLAGS = 4'd6;
    localparam logic [3:0] FUNC_TIMEOUT  = 4'd7;
    localparam logic [3:0] FUNC_ACCEL    = 4'd8;
    localparam logic [3:0] FUNC_DECEL    = 4'd9;
    localparam logic [3:0] FUNC_START    = 4'd10;
    localparam logic [3:0] FUNC_ERROR    = 4'd11;

    // Packet header and sub-command bytes
    localparam logic [7:0] HDR_ALLSPEED = 8'hE1;
    localparam logic [7:0] HDR_SPEED    = 8'hD1;
    localparam logic [7:0] HDR_BRAKE    = 8'hB1;
    localparam logic [7:0] HDR_CRC      = 8'h8B;
    localparam logic [7:0] HDR_FLAGS    = 8'hA9;
    localparam logic [7:0] HDR_SETTING  = 8'h9C;
    localparam logic [7:0] SUB_TIMEOUT  = 8'h05;
    localparam logic [7:0] SUB_ACCEL    = 8'h0A;
    localparam logic [7:0] SUB_DECEL    = 8'h0E;
    localparam logic [7:0] SUB_START    = 8'h12;
    localparam logic [7:0] SUB_ERROR    = 8'h07;
    localparam logic [7:0] CRC_ON_ARG0  = 8'h04;
    localparam logic [7:0] CRC_ON_ARG1  = 8'hFB;
    localparam logic [7:0] CRC_OFF_ARG0 = 8'h00;
    localparam logic [7:0] CRC_OFF_ARG1 = 8'hFF;
    localparam logic [7:0] TIMEOUT_SCALE = 8'd250;
    localparam logic [7:0] CRC7_POLY    = 8'h91;

    localparam logic [1:0] MOTOR_BOTH   = 2'd3;

    // Register map
    localparam logic [2:0] ADDR_CRC_ENABLE = 3'd0;

    // Default depth of the packet queue between front and back
    localparam int unsigned MCPE_QUEUE_DEPTH = 2;

    localparam int unsigned PKT_MAX = 5;

    // One classified request: packet bytes, packet length and the two-motor flag
    typedef struct packed {
        logic [PKT_MAX-1:0][7:0] bytes;
        logic [2:0]              len;
        logic                    dual;
    } pkt_desc_t;

    // Fold one byte into a reflected CRC-7 (poly 0x91, one bit per step)
    function automatic logic [7:0] crc7_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = c ^ CRC7_POLY;
            end
            c = {1'b0, c[7:1]};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/mcpe_front.sv
// Request classifier: turns one command request into a packet descriptor.
`default_nettype none

module mcpe_front
    import mcpe_pkg::*;
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [3:0]  func,
    input  wire logic [15:0] value,
    input  wire logic [1:0]  motor,
    input  wire logic        q_full,
    output logic             q_push,
    output pkt_desc_t        q_desc
);

    logic        known;
    logic        per_motor;
    logic [15:0] tmo;

    assign tmo = 16'(value[7:0]) * 16'(TIMEOUT_SCALE);

    always_comb begin
        known     = 1'b1;
        per_motor = 1'b0;
        q_desc.bytes    = '0;
        q_desc.bytes[1] = {6'b0, motor};
        q_desc.len      = 3'd3;
        unique case (func) inside
            FUNC_ALLSPEED: begin
                q_desc.bytes[0] = HDR_ALLSPEED;
                q_desc.bytes[1] = {1'b0, value[6:0]};
                q_desc.bytes[2] = {1'b0, value[13:7]};
            end
            FUNC_SPEED, FUNC_BRAKE: begin
                q_desc.bytes[0] = (func == FUNC_SPEED) ? HDR_SPEED : HDR_BRAKE;
                q_desc.bytes[2] = {1'b0, value[6:0]};
                q_desc.bytes[3] = {1'b0, value[13:7]};
                q_desc.len      = 3'd4;
                per_motor       = 1'b1;
            end
            FUNC_CRCON: begin
                q_desc.bytes[0] = HDR_CRC;
                q_desc.bytes[1] = CRC_ON_ARG0;
                q_desc.bytes[2] = CRC_ON_ARG1;
            end
            FUNC_CRCOFF: begin
                q_desc.bytes[0] = HDR_CRC;
                q_desc.bytes[1] = CRC_OFF_ARG0;
                q_desc.bytes[2] = CRC_OFF_ARG1;
            end
            FUNC_CLRFLAGS: begin
                q_desc.bytes[0] = HDR_FLAGS;
                q_desc.bytes[1] = ~{2'b0, value[5:0]};
                q_desc.bytes[2] = ~{6'b0, value[9], 1'b0};
            end
            FUNC_SETFLAGS: begin
                q_desc.bytes[0] = HDR_FLAGS;
                q_desc.bytes[1] = {2'b0, value[5:0]};
                q_desc.bytes[2] = {6'b0, value[9], 1'b0};
            end
            FUNC_TIMEOUT: begin
                q_desc.bytes[0] = HDR_SETTING;
                q_desc.bytes[1] = 8'h00;
                q_desc.bytes[2] = SUB_TIMEOUT;
                q_desc.bytes[3] = tmo[7:0];
                q_desc.bytes[4] = tmo[15:8];
                q_desc.len      = 3'd5;
            end
            FUNC_ACCEL, FUNC_DECEL, FUNC_START: begin
                q_desc.bytes[0] = HDR_SETTING;
                q_desc.bytes[2] = (func == FUNC_ACCEL) ? SUB_ACCEL :
                                  (func == FUNC_DECEL) ? SUB_DECEL : SUB_START;
                q_desc.bytes[3] = value[7:0];
                q_desc.bytes[4] = value[15:8];
                q_desc.len      = 3'd5;
                per_motor       = 1'b1;
            end
            FUNC_ERROR: begin
                q_desc.bytes[0] = HDR_SETTING;
                q_desc.bytes[1] = 8'h00;
                q_desc.bytes[2] = SUB_ERROR;
                q_desc.bytes[3] = {1'b0, value[6:0]};
                q_desc.len      = 3'd4;
            end
            default: begin
                known = 1'b0;
            end
        endcase
        q_desc.dual = per_motor && (motor == MOTOR_BOTH);
        // First of the two packets goes to motor one
        if (q_desc.dual) begin
            q_desc.bytes[1] = 8'h01;
        end
    end

    // Accept whenever the queue has room; drop unknown commands
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && known;

endmodule

`default_nettype wire

// File: src/mcpe_queue.sv
// Small descriptor queue decoupling the classifier from the byte serialiser.
`default_nettype none

module mcpe_queue
    import mcpe_pkg::*;
#(
    parameter int unsigned DEPTH = MCPE_QUEUE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire pkt_desc_t push_desc,
    output logic           full,
    input  wire logic      pop,
    output logic           not_empty,
    output pkt_desc_t      head_desc
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pkt_desc_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_desc = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

// File: src/mcpe_back.sv
// Byte serialiser: walks descriptors, adds CRC byte if enabled, drives the output register.
`default_nettype none

module mcpe_back
    import mcpe_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      crc_enable,
    input  wire logic      q_not_empty,
    input  wire pkt_desc_t q_head,
    output logic           q_pop,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tuser,
    output logic           m_tlast
);

    logic       busy_reg, busy_next;
    logic       second_reg, second_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] crc_reg, crc_next;
    pkt_desc_t  desc_reg;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       pend_reg;
    logic       last_reg;

    logic       adv;
    logic       is_crc;
    logic       pkt_end;
    logic       req_end;
    logic [7:0] data_byte;
    logic [7:0] cur_byte;

    assign adv     = busy_reg && (!valid_reg || m_tready);
    assign is_crc  = (idx_reg == desc_reg.len);
    assign pkt_end = is_crc || ((idx_reg == desc_reg.len - 3'd1) && !crc_enable);
    assign req_end = pkt_end && (!desc_reg.dual || second_reg);
    assign q_pop   = q_not_empty && (!busy_reg || (adv && req_end));

    always_comb begin
        case (idx_reg)
            3'd0:    data_byte = desc_reg.bytes[0];
            3'd1:    data_byte = second_reg ? 8'h02 : desc_reg.bytes[1];
            3'd2:    data_byte = desc_reg.bytes[2];
            3'd3:    data_byte = desc_reg.bytes[3];
            3'd4:    data_byte = desc_reg.bytes[4];
            default: data_byte = 8'h00;
        endcase
        cur_byte = is_crc ? crc_reg : data_byte;
    end

    always_comb begin
        busy_next   = busy_reg;
        second_next = second_reg;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        if (adv) begin
            if (pkt_end) begin
                idx_next = '0;
                crc_next = '0;
                if (req_end) begin
                    busy_next   = 1'b0;
                    second_next = 1'b0;
                end else begin
                    second_next = 1'b1;
                end
            end else begin
                idx_next = idx_reg + 3'd1;
                crc_next = crc7_byte(crc_reg, data_byte);
            end
        end
        // Load the next descriptor straight away so requests run without a gap
        if (q_pop) begin
            busy_next   = 1'b1;
            second_next = 1'b0;
            idx_next    = '0;
            crc_next    = '0;
        end
        valid_next = valid_reg;
        if (!valid_reg || m_tready) begin
            valid_next = adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            second_reg <= 1'b0;
            idx_reg    <= '0;
            crc_reg    <= '0;
            valid_reg  <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            second_reg <= second_next;
            idx_reg    <= idx_next;
            crc_reg    <= crc_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            desc_reg <= q_head;
        end
        if (adv) begin
            byte_reg <= cur_byte;
            pend_reg <= pkt_end;
            last_reg <= req_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = pend_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// File: src/motor_command_packet_encoder.sv
// Top level of the motor command packet encoder: config register, classifier, queue, serialiser.
`default_nettype none

// Channel   | Dir | Handshake          | Payload
// s_        | in  | s_tvalid/s_tready  | s_tdata: func[3:0], value[19:4], motor[21:20]
// m_        | out | m_tvalid/m_tready  | m_tdata: out_byte; m_tuser: packet_end; m_tlast: last
// APB       | in  | psel/penable/pready| register 0 at 0x0: crc_enable (bit 0)
//
// Each request yields three to twelve bytes, one byte per cycle while the output is not
// stalled; the next request's bytes follow the previous one's without a gap when the
// queue already holds it. Reset is synchronous and active low; it empties the queue
// and the output register and clears crc_enable. A stalled output holds its item; the
// classifier keeps taking requests until the queue fills. Unknown command codes are
// taken and dropped.

module motor_command_packet_encoder
    import mcpe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = MCPE_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // func[3:0], value[19:4], motor[21:20], zero[23:22]
    // byte stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte[7:0]
    output logic             m_tuser,   // packet_end[0]
    output logic             m_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic      crc_en_reg;
    logic      cfg_wr;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_not_empty;
    pkt_desc_t push_desc;
    pkt_desc_t head_desc;

    // Configuration port: single word-aligned register, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_en_reg <= 1'b0;
        end else if (cfg_wr && (paddr[2] == ADDR_CRC_ENABLE[2])) begin
            crc_en_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == ADDR_CRC_ENABLE[2]) ? {31'b0, crc_en_reg} : 32'b0;

    // Front: classify each request into a packet descriptor
    mcpe_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tdata[3:0]),
        .value    (s_tdata[19:4]),
        .motor    (s_tdata[21:20]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (push_desc)
    );

    // Queue: hold descriptors while the serialiser is busy
    mcpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_desc (head_desc)
    );

    // Back: emit bytes, append CRC when enabled, split two-motor requests
    mcpe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .crc_enable  (crc_en_reg),
        .q_not_empty (q_not_empty),
        .q_head      (head_desc),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// File: verif/motor_command_packet_encoder_checker.sv
// Scoreboard for the motor command packet encoder: predicts command bytes and checks the byte stream.
`default_nettype none

module motor_command_packet_encoder_checker
    import mcpe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // func[3:0], value[19:4], motor[21:20], zero[23:22]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // out_byte[7:0]
    input  wire logic        m_tuser,   // packet_end[0]
    input  wire logic        m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               bytes_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       req_last;
    } cmd_byte_t;

    cmd_byte_t  byte_q[$];
    logic       crc_on = 1'b0;
    int         errors = 0;

    // Queue one packet's bytes, with the reflected CRC-7 byte when enabled
    function automatic void queue_packet(input logic [7:0] pkt [PKT_MAX], input int unsigned n,
                                         input logic final_pkt);
        logic [7:0]  crc;
        int unsigned total;
        cmd_byte_t   b;
        crc = 8'h00;
        for (int unsigned i = 0; i < n; i++) begin
            crc = crc ^ pkt[i];
            for (int k = 0; k < 8; k++) begin
                crc = crc[0] ? ((crc ^ CRC7_POLY) >> 1) : (crc >> 1);
            end
        end
        total = n + (crc_on ? 1 : 0);
        for (int unsigned i = 0; i < total; i++) begin
            b.data     = (i < n) ? pkt[i] : crc;
            b.pkt_end  = (i + 1 == total);
            b.req_last = (i + 1 == total) && final_pkt;
            byte_q.push_back(b);
        end
    endfunction

    // Build the packet(s) for one request; unknown codes yield nothing
    function automatic void predict_request(input logic [3:0] func, input logic [15:0] value,
                                            input logic [1:0] motor);
        logic [7:0]  pkt [PKT_MAX];
        int unsigned n;
        logic        dual;
        logic [15:0] secs;
        foreach (pkt[i]) pkt[i] = 8'h00;
        n       = 0;
        dual    = 1'b0;
        pkt[1]  = {6'b0, motor};
        secs    = 16'(value[7:0]) * 16'(TIMEOUT_SCALE);
        case (func) inside
            FUNC_ALLSPEED: begin
                pkt[0] = HDR_ALLSPEED;
                pkt[1] = {1'b0, value[6:0]};
                pkt[2] = {1'b0, value[13:7]};
                n = 3;
            end
            FUNC_SPEED, FUNC_BRAKE: begin
                pkt[0] = (func == FUNC_SPEED) ? HDR_SPEED : HDR_BRAKE;
                pkt[2] = {1'b0, value[6:0]};
                pkt[3] = {1'b0, value[13:7]};
                n = 4;
                dual = 1'b1;
            end
            FUNC_CRCON: begin
                pkt[0] = HDR_CRC;
                pkt[1] = CRC_ON_ARG0;
                pkt[2] = CRC_ON_ARG1;
                n = 3;
            end
            FUNC_CRCOFF: begin
                pkt[0] = HDR_CRC;
                pkt[1] = CRC_OFF_ARG0;
                pkt[2] = CRC_OFF_ARG1;
                n = 3;
            end
            FUNC_CLRFLAGS: begin
                pkt[0] = HDR_FLAGS;
                pkt[1] = ~{2'b0, value[5:0]};
                pkt[2] = ~{6'b0, value[9], 1'b0};
                n = 3;
            end
            FUNC_SETFLAGS: begin
                pkt[0] = HDR_FLAGS;
                pkt[1] = {2'b0, value[5:0]};
                pkt[2] = {6'b0, value[9], 1'b0};
                n = 3;
            end
            FUNC_TIMEOUT: begin
                pkt[0] = HDR_SETTING;
                pkt[1] = 8'h00;
                pkt[2] = SUB_TIMEOUT;
                pkt[3] = secs[7:0];
                pkt[4] = secs[15:8];
                n = 5;
            end
            FUNC_ACCEL, FUNC_DECEL, FUNC_START: begin
                pkt[0] = HDR_SETTING;
                pkt[2] = (func == FUNC_ACCEL) ? SUB_ACCEL :
                         (func == FUNC_DECEL) ? SUB_DECEL : SUB_START;
                pkt[3] = value[7:0];
                pkt[4] = value[15:8];
                n = 5;
                dual = 1'b1;
            end
            FUNC_ERROR: begin
                pkt[0] = HDR_SETTING;
                pkt[1] = 8'h00;
                pkt[2] = SUB_ERROR;
                pkt[3] = {1'b0, value[6:0]};
                n = 4;
            end
            default: ;
        endcase
        if (n == 0) return;
        if (dual && motor == MOTOR_BOTH) begin
            pkt[1] = 8'h01;
            queue_packet(pkt, n, 1'b0);
            pkt[1] = 8'h02;
            queue_packet(pkt, n, 1'b1);
        end else begin
            queue_packet(pkt, n, 1'b1);
        end
    endfunction

    always @(posedge aclk) begin : watch
        cmd_byte_t want;
        if (!aresetn) begin
            byte_q.delete();
            crc_on = 1'b0;
        end else begin
            if (psel && penable && pready && paddr == ADDR_CRC_ENABLE) begin
                if (pwrite) begin
                    crc_on = pwdata[0];
                end else if (prdata != {31'b0, crc_on}) begin
                    $error("prdata: expected %h, actual %h", {31'b0, crc_on}, prdata);
                    errors++;
                end
            end
            if (s_tvalid && s_tready)
                predict_request(s_tdata[3:0], s_tdata[19:4], s_tdata[21:20]);
            if (m_tvalid && m_tready) begin
                if (byte_q.size() == 0) begin
                    $error("out_byte: none expected, actual %h", m_tdata);
                    errors++;
                end else begin
                    want = byte_q.pop_front();
                    if (m_tdata != want.data) begin
                        $error("out_byte: expected %h, actual %h", want.data, m_tdata);
                        errors++;
                    end
                    if (m_tuser != want.pkt_end) begin
                        $error("packet_end: expected %b, actual %b", want.pkt_end, m_tuser);
                        errors++;
                    end
                    if (m_tlast != want.req_last) begin
                        $error("last: expected %b, actual %b", want.req_last, m_tlast);
                        errors++;
                    end
                end
            end
        end
        fail_count <= errors;
        bytes_due  <= byte_q.size();
    end

endmodule

`default_nettype wire

// File: verif/motor_command_packet_encoder_test.sv
// Testbench top for the motor command packet encoder: clock, reset, stimulus and verdict.
`default_nettype none

module motor_command_packet_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mcpe_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;     // func[3:0], value[19:4], motor[21:20], zero[23:22]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // out_byte[7:0]
    logic        m_tuser;           // packet_end[0]
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int   fail_count;
    int   bytes_due;
    logic calm          = 1'b0;     // high: neither side idles
    int   requests_sent = 0;
    int   ignored_sent  = 0;

    motor_command_packet_encoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    motor_command_packet_encoder_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .bytes_due  (bytes_due)
    );

    always #1 aclk = ~aclk;

    // Stall the byte side with a chance of roughly 12 in 100, never during a calm stretch
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 12);
    end

    // Offer one request and hold it until the handshake takes it.
    // Idle cycles go in front of the item so that valid is never dropped and
    // raised again within one time step.
    task automatic send_request(input logic [3:0] func, input logic [15:0] value,
                                input logic [1:0] motor);
        while (!calm && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, motor, value, func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        if (func > FUNC_ERROR) ignored_sent++;
    endtask

    // One APB transfer to the crc_enable register: setup cycle, then access until pready,
    // then the bus returns to idle
    task automatic apb_access(input logic write, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ADDR_CRC_ENABLE;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop valid, wait until every predicted byte has left, then give dropped
    // requests time to clear
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bytes_due != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Change crc_enable only while the block is idle; read it back for the checker.
    // Upper write bits carry noise, the register keeps bit 0 alone.
    task automatic set_crc(input logic on);
        drain();
        apb_access(1'b1, {31'($urandom()), on});
        apb_access(1'b0, $urandom());
    endtask

    // Random requests: mostly real commands, a few unused codes, some extreme values.
    // Requests with indexes in [calm_from, calm_to) run with no idling on either side.
    task automatic random_phase(input int count, input int calm_from, input int calm_to);
        logic [3:0]  func;
        logic [15:0] value;
        int          pick;
        for (int i = 0; i < count; i++) begin
            calm <= (i >= calm_from) && (i < calm_to);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                func = 4'(FUNC_ERROR + $urandom_range(1, 4));
            else
                func = 4'($urandom_range(0, FUNC_ERROR));
            pick = $urandom_range(0, 99);
            value = (pick < 6) ? 16'h0000 : (pick < 12) ? 16'hFFFF : 16'($urandom());
            send_request(func, value, 2'($urandom_range(0, 3)));
        end
        calm <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pass with the CRC byte on: field extremes, every command,
        // both motors at once, flag bits inverted and the timeout product at its top
        set_crc(1'b1);
        send_request(FUNC_ALLSPEED, 16'h0000, 2'd0);
        send_request(FUNC_ALLSPEED, 16'hFFFF, 2'd3);
        send_request(FUNC_SPEED,    16'h0000, 2'd0);
        send_request(FUNC_SPEED,    16'hFFFF, MOTOR_BOTH);
        send_request(FUNC_BRAKE,    16'h1234, 2'd1);
        send_request(FUNC_BRAKE,    16'h3FFF, 2'd2);
        send_request(FUNC_CRCON,    16'hFFFF, 2'd2);
        send_request(FUNC_CRCOFF,   16'h0000, 2'd1);
        send_request(FUNC_CLRFLAGS, 16'h0000, 2'd0);
        send_request(FUNC_CLRFLAGS, 16'hFFFF, 2'd3);
        send_request(FUNC_SETFLAGS, 16'hFFFF, 2'd1);
        send_request(FUNC_SETFLAGS, 16'h0200, 2'd0);
        send_request(FUNC_TIMEOUT,  16'hFFFF, 2'd3);
        send_request(FUNC_TIMEOUT,  16'h0000, 2'd0);
        send_request(FUNC_ACCEL,    16'hFFFF, MOTOR_BOTH);
        send_request(FUNC_DECEL,    16'h0000, 2'd2);
        send_request(FUNC_START,    16'hA5C3, 2'd1);
        send_request(FUNC_START,    16'hFFFF, 2'd0);
        send_request(FUNC_ERROR,    16'hFFFF, 2'd3);
        send_request(FUNC_ERROR,    16'h0000, 2'd0);
        // Unused codes above the error command: taken and dropped
        for (int c = 1; c <= 4; c++)
            send_request(4'(FUNC_ERROR + c), 16'($urandom()), 2'($urandom_range(0, 3)));

        // Random phases, alternating the CRC setting; one holds a long calm stretch
        set_crc(1'b0);
        random_phase(110, 0, 0);
        set_crc(1'b1);
        random_phase(110, 30, 80);
        set_crc(1'b0);
        random_phase(110, 0, 0);

        drain();

        $display("Sent %0d requests, %0d of them unused codes, with crc_enable off and on",
                 requests_sent, ignored_sent);
        $display("Both sides idled at random, with a calm stretch in the middle phase");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Stop a hung run; a correct one needs a small fraction of this
    initial begin
        #500us;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
